// File: rtl/dbr_pkg.sv
// Package for the DMA byte realigner: result type, register indexes and lane helpers.
`timescale 1ns / 1ps

package dbr_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SRC_OFFSET = 2'd0,
    CFG_DST_OFFSET = 2'd1,
    CFG_BYTE_COUNT = 2'd2
  } cfg_idx_t;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned LANES   = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned OFFS_W  = 3;

  typedef struct packed {
    logic [DATA_W-1:0] dst_word;
    logic [LANES-1:0]  byte_enable;
    logic              dst_last;
  } res_t;

  // Mask covering the low n byte lanes of a 64-bit word.
  function automatic logic [DATA_W-1:0] lane_mask(input logic [3:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < LANES; i++) begin
      if (4'(i) < n) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  // Byte enables for the low n lanes.
  function automatic logic [LANES-1:0] en_bits(input logic [3:0] n);
    logic [LANES-1:0] e;
    e = '0;
    for (int i = 0; i < LANES; i++) begin
      if (4'(i) < n) e[i] = 1'b1;
    end
    return e;
  endfunction

endpackage

// File: rtl/dma_byte_realigner.sv
// DMA byte realigner: merges aligned source words into destination-aligned words.
// Results are registered in the queue when their item is accepted and leave it in order.
// Throughput: one item per cycle while in_stall is low; an item closing a transfer with
// both a full and a tail word makes two results, drained one per cycle while out_stall
// is low, from a 4-entry queue. in_stall rises when fewer than two entries are free.
// Reset (rst_n low, synchronous) clears registers, transfer state and the queue.
`timescale 1ns / 1ps

module dma_byte_realigner #(
  parameter int unsigned WORD_BYTES = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_index,
  input  logic [dbr_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dbr_pkg::DATA_W-1:0]  in_src_word,
  input  logic                        in_src_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dbr_pkg::DATA_W-1:0]  out_dst_word,
  output logic [dbr_pkg::LANES-1:0]   out_byte_enable,
  output logic                        out_dst_last
);
  import dbr_pkg::*;

  localparam int unsigned HB = $clog2(WORD_BYTES);
  localparam int unsigned NB = HB + 1;
  localparam logic [NB-1:0] WB_N = NB'(WORD_BYTES);
  localparam logic [3:0]    WB_4 = 4'(WORD_BYTES);

  // Configuration registers.
  logic [OFFS_W-1:0] src_offset_r;
  logic [OFFS_W-1:0] dst_offset_r;
  logic [CFG_W-1:0]  byte_count_r;

  // Transfer state.
  logic [DATA_W-1:0]     held_word_r, held_word_nxt;
  logic [HB-1:0]         held_bytes_r, held_bytes_nxt;
  logic [COUNT_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic                  first_done_r, first_done_nxt;
  logic                  lead_pending_r, lead_pending_nxt;

  // Result queue.
  res_t       fifo_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;

  logic in_acc, out_acc;
  logic push_a, push_b;
  res_t res_a, res_b;

  // Combinational datapath signals.
  logic [3:0]            src_m4, dst_m4;
  logic [HB-1:0]         src_mod, dst_mod, skip, h, nh, st;
  logic [COUNT_BITS-1:0] eff_left;
  logic [31:0]           count_ext;
  logic [NB-1:0]         avail, take, total, rsh;
  logic [DATA_W-1:0]     word_mask, hw, fresh, lo, hi, nw;
  logic [LANES-1:0]      en_full;
  logic                  start, lead, lead2, emit_full, tail_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_offset_r <= '0;
      dst_offset_r <= '0;
      byte_count_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SRC_OFFSET: src_offset_r <= cfg_wdata[OFFS_W-1:0];
        CFG_DST_OFFSET: dst_offset_r <= cfg_wdata[OFFS_W-1:0];
        CFG_BYTE_COUNT: byte_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = (count_r > 3'd2);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (count_r != 3'd0);
  assign out_acc  = out_valid && !out_stall;

  always_comb begin
    word_mask = lane_mask(WB_4);

    // Offsets of 8 or more lanes wrap; the raw value is below twice the word.
    src_m4  = {1'b0, src_offset_r};
    dst_m4  = {1'b0, dst_offset_r};
    if (src_m4 >= WB_4) src_m4 = src_m4 - WB_4;
    if (dst_m4 >= WB_4) dst_m4 = dst_m4 - WB_4;
    src_mod = src_m4[HB-1:0];
    dst_mod = dst_m4[HB-1:0];

    start     = !first_done_r;
    count_ext = {16'd0, byte_count_r};
    eff_left  = start ? count_ext[COUNT_BITS-1:0] : bytes_left_r;
    skip      = start ? src_mod : '0;
    h         = start ? dst_mod : held_bytes_r;
    hw        = start ? '0 : held_word_r;
    lead      = start ? 1'b1 : lead_pending_r;

    avail = WB_N - {1'b0, skip};
    take  = (eff_left < COUNT_BITS'(avail)) ? eff_left[NB-1:0] : avail;
    bytes_left_nxt = eff_left - COUNT_BITS'(take);

    fresh = (in_src_word >> {skip, 3'b000}) & lane_mask(4'(take));
    lo    = (hw | (fresh << {h, 3'b000})) & word_mask;
    rsh   = WB_N - {1'b0, h};
    hi    = (h != '0) ? (fresh >> {rsh, 3'b000}) : '0;
    total = {1'b0, h} + take;

    emit_full = (total >= WB_N);
    en_full   = en_bits(WB_4) & ~(lead ? en_bits(4'(dst_mod)) : '0);
    nh        = emit_full ? HB'(total - WB_N) : total[HB-1:0];
    nw        = emit_full ? (hi & word_mask) : lo;
    lead2     = lead && !emit_full;
    st        = lead2 ? dst_mod : '0;
    tail_ok   = (nh > st);

    // Full word if one fills; the last item ends on a tail, that word or an end marker.
    res_a = '0;
    res_b = '0;
    push_a = 1'b0;
    push_b = 1'b0;
    if (emit_full) begin
      push_a            = 1'b1;
      res_a.dst_word    = lo;
      res_a.byte_enable = en_full;
      res_a.dst_last    = in_src_last && !tail_ok;
      push_b            = in_src_last && tail_ok;
      res_b.dst_word    = nw;
      res_b.byte_enable = en_bits(4'(nh)) & ~en_bits(4'(st));
      res_b.dst_last    = 1'b1;
    end else if (in_src_last) begin
      push_a         = 1'b1;
      res_a.dst_last = 1'b1;
      if (tail_ok) begin
        res_a.dst_word    = nw;
        res_a.byte_enable = en_bits(4'(nh)) & ~en_bits(4'(st));
      end
    end

    if (in_src_last) begin
      held_word_nxt    = '0;
      held_bytes_nxt   = '0;
      bytes_left_nxt   = '0;
      first_done_nxt   = 1'b0;
      lead_pending_nxt = 1'b0;
    end else begin
      held_word_nxt    = nw;
      held_bytes_nxt   = nh;
      first_done_nxt   = 1'b1;
      lead_pending_nxt = lead2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_word_r    <= '0;
      held_bytes_r   <= '0;
      bytes_left_r   <= '0;
      first_done_r   <= 1'b0;
      lead_pending_r <= 1'b0;
    end else if (in_acc) begin
      held_word_r    <= held_word_nxt;
      held_bytes_r   <= held_bytes_nxt;
      bytes_left_r   <= bytes_left_nxt;
      first_done_r   <= first_done_nxt;
      lead_pending_r <= lead_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && push_a) fifo_r[wr_ptr_r] <= res_a;
    if (in_acc && push_b) fifo_r[wr_ptr_r + 2'd1] <= res_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + ((in_acc && push_a) ? 2'd1 : 2'd0)
                           + ((in_acc && push_b) ? 2'd1 : 2'd0);
      rd_ptr_r <= rd_ptr_r + (out_acc ? 2'd1 : 2'd0);
      count_r  <= count_r + ((in_acc && push_a) ? 3'd1 : 3'd0)
                          + ((in_acc && push_b) ? 3'd1 : 3'd0)
                          - (out_acc ? 3'd1 : 3'd0);
    end
  end

  assign out_dst_word    = fifo_r[rd_ptr_r].dst_word;
  assign out_byte_enable = fifo_r[rd_ptr_r].byte_enable;
  assign out_dst_last    = fifo_r[rd_ptr_r].dst_last;

endmodule

// File: rtl/dbr_checker.sv
// Port-level assertions for the DMA byte realigner and the bind that attaches them.
`timescale 1ns / 1ps

module dbr_checker #(
  parameter int unsigned WORD_BYTES = 8
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [dbr_pkg::DATA_W-1:0]  out_dst_word,
  input logic [dbr_pkg::LANES-1:0]   out_byte_enable,
  input logic                        out_dst_last
);
  import dbr_pkg::*;

  function automatic logic [DATA_W-1:0] expand_en(input logic [LANES-1:0] en);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < LANES; i++) begin
      m[i*8 +: 8] = {8{en[i]}};
    end
    return m;
  endfunction

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dst_word) &&
      $stable(out_byte_enable) && $stable(out_dst_last))
    else $error("stalled result changed");

  // The queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Lanes that are not enabled carry zero.
  a_lanes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dst_word & ~expand_en(out_byte_enable)) == '0)
    else $error("disabled lane holds data");

  // Only the final word may be partial at the top lane; an empty word ends a transfer.
  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dst_last |-> out_byte_enable[WORD_BYTES-1])
    else $error("non-final word missing its top lane");

endmodule

bind dma_byte_realigner dbr_checker #(.WORD_BYTES(WORD_BYTES)) u_dbr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_dst_word    (out_dst_word),
  .out_byte_enable (out_byte_enable),
  .out_dst_last    (out_dst_last)
);

// File: bench/tb_dma_byte_realigner.sv
// Self-checking testbench for the DMA byte realigner with a word-level scoreboard.
`timescale 1ns / 1ps

module tb_dma_byte_realigner;
  import dbr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_ITEMS = 1400;

  // Tracks the realigner's transfer state and predicts each destination word.
  class realign_tracker;
    logic [2:0]  src_off;
    logic [2:0]  dst_off;
    logic [15:0] byte_count;
    logic [63:0] held_word;
    int unsigned held_bytes;
    logic [15:0] bytes_left;
    bit          in_xfer;
    bit          lead_open;
    res_t        pending_dst_words[$];
    int          errors;

    function new();
      src_off    = '0;
      dst_off    = '0;
      byte_count = '0;
      held_word  = '0;
      held_bytes = 0;
      bytes_left = '0;
      in_xfer    = 1'b0;
      lead_open  = 1'b0;
      errors     = 0;
    endfunction

    function logic [63:0] lanes_below(int unsigned n);
      if (n >= 8) return '1;
      return (64'd1 << (n * 8)) - 64'd1;
    endfunction

    function logic [7:0] enables_below(int unsigned n);
      if (n >= 8) return 8'hFF;
      return (8'd1 << n) - 8'd1;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] value);
      case (idx)
        CFG_SRC_OFFSET: src_off = value[2:0];
        CFG_DST_OFFSET: dst_off = value[2:0];
        CFG_BYTE_COUNT: byte_count = value;
        default: ;
      endcase
    endfunction

    function void push_word(logic [63:0] w, logic [7:0] be, logic l);
      res_t r;
      r.dst_word    = w;
      r.byte_enable = be;
      r.dst_last    = l;
      pending_dst_words.push_back(r);
    endfunction

    // Accepted source word: merge it behind the held bytes and queue what it completes.
    function void take_src_word(logic [63:0] w, logic l);
      int unsigned skip, take, h, total, lead;
      logic [63:0] fresh, lo, hi;
      logic [7:0]  be;
      int          made;
      skip = 0;
      made = 0;
      if (!in_xfer) begin
        bytes_left = byte_count;
        held_word  = '0;
        held_bytes = 32'(dst_off);
        skip       = 32'(src_off);
        in_xfer    = 1'b1;
        lead_open  = 1'b1;
      end
      take = 8 - skip;
      if (take > 32'(bytes_left)) take = 32'(bytes_left);
      bytes_left = bytes_left - 16'(take);
      fresh = (w >> (skip * 8)) & lanes_below(take);
      h     = held_bytes;
      lo    = held_word | (fresh << (h * 8));
      hi    = (h > 0) ? (fresh >> ((8 - h) * 8)) : '0;
      total = h + take;
      if (total >= 8) begin
        be = 8'hFF;
        if (lead_open) be &= ~enables_below(32'(dst_off));
        push_word(lo, be, 1'b0);
        made++;
        lead_open  = 1'b0;
        held_word  = hi;
        held_bytes = total - 8;
      end else begin
        held_word  = lo;
        held_bytes = total;
      end
      if (l) begin
        lead = lead_open ? 32'(dst_off) : 32'd0;
        if (held_bytes > lead) begin
          push_word(held_word, enables_below(held_bytes) & ~enables_below(lead), 1'b1);
        end else if (made > 0) begin
          // Nothing left over, so the full word just queued closes the transfer.
          pending_dst_words[pending_dst_words.size() - 1].dst_last = 1'b1;
        end else begin
          push_word('0, '0, 1'b1);
        end
        held_word  = '0;
        held_bytes = 0;
        bytes_left = '0;
        in_xfer    = 1'b0;
        lead_open  = 1'b0;
      end
    endfunction

    function void check_dst_word(logic [63:0] w, logic [7:0] be, logic l);
      res_t exp_r;
      if (pending_dst_words.size() == 0) begin
        $error("unexpected destination word %h, byte_enable %h, dst_last %b", w, be, l);
        errors++;
        return;
      end
      exp_r = pending_dst_words.pop_front();
      if (w !== exp_r.dst_word) begin
        $error("dst_word: expected %h, got %h", exp_r.dst_word, w);
        errors++;
      end
      if (be !== exp_r.byte_enable) begin
        $error("byte_enable: expected %h, got %h", exp_r.byte_enable, be);
        errors++;
      end
      if (l !== exp_r.dst_last) begin
        $error("dst_last: expected %b, got %b", exp_r.dst_last, l);
        errors++;
      end
    endfunction

    function int pending();
      return pending_dst_words.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [1:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [DATA_W-1:0]   in_src_word;
  logic                in_src_last;
  logic                out_valid;
  logic                out_stall;
  logic [DATA_W-1:0]   out_dst_word;
  logic [LANES-1:0]    out_byte_enable;
  logic                out_dst_last;

  realign_tracker tracker = new();
  int             cycle_count = 0;
  int             items_sent = 0;
  int             burst_left = 0;
  bit             steady = 1'b0;
  bit             valid_up = 1'b0;
  bit             hold_req = 1'b0;

  dma_byte_realigner uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_src_word     (in_src_word),
    .in_src_last     (in_src_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dst_word    (out_dst_word),
    .out_byte_enable (out_byte_enable),
    .out_dst_last    (out_dst_last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_dma_byte_realigner: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.take_src_word(in_src_word, in_src_last);
      if (out_valid && !out_stall) tracker.check_dst_word(out_dst_word, out_byte_enable,
                                                          out_dst_last);
    end
  end

  // Receiver: changes its stall pattern at random intervals, and once holds off
  // for a long stretch so that the block's queue fills and it stalls its input.
  initial begin : receiver
    int seg, mode, per;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 200);
      per  = $urandom_range(2, 5);
      for (int i = 0; i < seg && !hold_req; i++) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= (i % per == 0);
        endcase
      end
    end
  end

  function automatic logic [63:0] pick_word();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic lower_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // Offers one source item and returns at the falling edge after it is taken.
  task automatic send_word(input logic [63:0] w, input logic l);
    in_valid    <= 1'b1;
    in_src_word <= w;
    in_src_last <= l;
    valid_up = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    items_sent++;
  endtask

  // Sender bursts: a random run of back-to-back items, then a short gap.
  task automatic pace();
    int gap;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 24);
    gap = $urandom_range(1, 6);
    lower_valid();
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain();
    lower_valid();
    while (tracker.pending() != 0) @(negedge clk);
    // An item that completes no word may still be in flight.
    repeat (4) @(negedge clk);
  endtask

  task automatic set_regs(input logic [15:0] src_v, input logic [15:0] dst_v,
                          input logic [15:0] cnt_v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SRC_OFFSET;
    cfg_wdata <= src_v;
    tracker.set_reg(CFG_SRC_OFFSET, src_v);
    @(negedge clk);
    cfg_index <= CFG_DST_OFFSET;
    cfg_wdata <= dst_v;
    tracker.set_reg(CFG_DST_OFFSET, dst_v);
    @(negedge clk);
    cfg_index <= CFG_BYTE_COUNT;
    cfg_wdata <= cnt_v;
    tracker.set_reg(CFG_BYTE_COUNT, cnt_v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_transfer(input int n_words);
    for (int i = 0; i < n_words; i++) begin
      send_word(pick_word(), i == n_words - 1);
      pace();
    end
  endtask

  function automatic int words_needed();
    int n;
    n = (int'(tracker.src_off) + int'(tracker.byte_count) + 7) / 8;
    return (n < 1) ? 1 : n;
  endfunction

  function automatic logic [2:0] pick_offset();
    int p;
    p = $urandom_range(0, 3);
    if (p == 0) return 3'd0;
    if (p == 1) return 3'd7;
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_count();
    int p;
    p = $urandom_range(0, 19);
    if (p < 12) return 16'($urandom_range(0, 40));
    if (p < 17) return 16'($urandom_range(41, 300));
    if (p < 19) return 16'($urandom_range(301, 2000));
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    int need, n_words, n_xfers, kind;
    logic [15:0] src_v, dst_v;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = CFG_SRC_OFFSET;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_src_word = '0;
    in_src_last = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers at reset: a zero-byte transfer yields one empty closing word.
    send_word(pick_word(), 1'b1);
    // A single full word whose own emission closes the transfer.
    set_regs(16'd0, 16'd0, 16'd8);
    send_word('1, 1'b1);
    // One byte from the top source lane.
    set_regs(16'd7, 16'd0, 16'd1);
    send_word(64'hAA55_AA55_AA55_AA55, 1'b1);
    // Destination starts in the top lane.
    set_regs(16'd0, 16'd7, 16'd9);
    run_transfer(2);
    // Both offsets at the top, plus a word after the count runs out.
    set_regs(16'd7, 16'd7, 16'd16);
    run_transfer(4);
    // Largest count cut short by an early last word.
    set_regs(16'd3, 16'd5, 16'hFFFF);
    run_transfer(5);
    // Empty transfer with reserved leading lanes.
    set_regs(16'd5, 16'd2, 16'd0);
    send_word('1, 1'b1);
    // Offset writes with the unused upper bits set.
    set_regs(16'hFFFF, 16'hFFF8, 16'hFFFF);
    run_transfer(2);

    // Long receiver hold-off while the sender keeps offering items.
    set_regs(16'd2, 16'd6, 16'd480);
    steady = 1'b1;
    hold_req = 1'b1;
    run_transfer(words_needed());
    steady = 1'b0;

    while (items_sent < RANDOM_ITEMS) begin
      src_v = (16'($urandom) & 16'hFFF8) | 16'(pick_offset());
      dst_v = (16'($urandom) & 16'hFFF8) | 16'(pick_offset());
      set_regs(src_v, dst_v, pick_count());
      steady = ($urandom_range(0, 4) == 0);
      n_xfers = $urandom_range(1, 5);
      for (int t = 0; t < n_xfers; t++) begin
        need = words_needed();
        kind = $urandom_range(0, 19);
        if (need > 260 || (need > 64 && kind < 18)) begin
          // Very long transfers are mostly cut short to keep the run brief.
          n_words = $urandom_range(1, 64);
        end else if (kind < 14) begin
          n_words = need;
        end else if (kind < 17) begin
          n_words = $urandom_range(1, need);
        end else begin
          n_words = need + $urandom_range(1, 3);
        end
        run_transfer(n_words);
      end
      steady = 1'b0;
    end

    drain();
    repeat (8) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_dma_byte_realigner: clean");
    end else begin
      $display("tb_dma_byte_realigner: errors");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/dbr_pkg.sv
rtl/dma_byte_realigner.sv
rtl/dbr_checker.sv
bench/tb_dma_byte_realigner.sv
